>>> src/jlti_pkg.sv
// Shared types and constants of the joint linear trajectory interpolator.
// No dependencies; the controller, the datapath and the top level use it.
`default_nettype none

package jlti_pkg;

   localparam int JOINTS    = 6;
   localparam int SEGMENTS  = 4;
   localparam int MAX_STEPS = 65535;

   localparam int ANG_W   = 21;
   localparam int LIM_W   = 20;
   localparam int SPEED_W = 20;
   localparam int RATE_W  = 10;
   localparam int STEP_W  = 16;
   localparam int SEG_W   = 2;
   localparam int CNT_W   = 3;
   localparam int JIDX_W  = 3;
   localparam int MAG_W   = 22;
   localparam int PROD_W  = MAG_W + RATE_W;
   localparam int DVD_W   = MAG_W + STEP_W;
   localparam int DVS_W   = 20;
   localparam int DCNT_W  = 6;
   localparam int OP_W    = 2;
   localparam int ST_W    = 3;
   localparam int CSR_W   = 2;

   localparam int IN_W  = 152;
   localparam int OUT_W = 136;

   localparam logic [LIM_W-1:0]   ANGLE_LIMIT_RST = 20'd368640;
   localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 20'd368640;
   localparam logic [RATE_W-1:0]  UPDATE_RATE_RST = 10'd20;

   localparam logic [CSR_W-1:0] CSR_ANGLE_LIMIT = 2'd0;
   localparam logic [CSR_W-1:0] CSR_SPEED_LIMIT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_UPDATE_RATE = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_FEEDBACK = 2'd0,
      OP_TARGET   = 2'd1,
      OP_TICK     = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_HOLD      = 3'd0,
      ST_MOVE      = 3'd1,
      ST_ACCEPT    = 3'd2,
      ST_ANGLE_REJ = 3'd3,
      ST_SPEED_REJ = 3'd4,
      ST_FULL      = 3'd5,
      ST_UNINIT    = 3'd6,
      ST_CAPPED    = 3'd7
   } status_type;

   typedef struct packed {
      logic load;
      logic fb;
      logic check;
      logic maxd_step;
      logic mul_n;
      logic div_step;
      logic n_store;
      logic tsel;
      logic tmul;
      logic tstore;
      logic tadv;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic             reject;
      logic             queue_empty;
      logic             short_seg;
      logic             j_last;
      logic             div_last;
      logic             out_free;
      logic [CNT_W-1:0] seg_count;
   } stat_type;

endpackage

`default_nettype wire

>>> src/jlti_ctrl.sv
// Controller of the interpolator: one-hot sequencer over the item kinds.
// Depends on jlti_pkg; drives the datapath commands and req_tready.
`default_nettype none

module jlti_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [jlti_pkg::OP_W-1:0] req_tuser,
   input  wire jlti_pkg::stat_type        stat,
   output jlti_pkg::cmd_type              cmd
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_FB     = 13'b0000000000010,
      S_CHECK  = 13'b0000000000100,
      S_MAXD   = 13'b0000000001000,
      S_MUL    = 13'b0000000010000,
      S_NDIV   = 13'b0000000100000,
      S_NSTORE = 13'b0000001000000,
      S_TSEL   = 13'b0000010000000,
      S_TMUL   = 13'b0000100000000,
      S_TDIV   = 13'b0001000000000,
      S_TSTORE = 13'b0010000000000,
      S_TADV   = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (jlti_pkg::opcode_type'(req_tuser))
                  jlti_pkg::OP_FEEDBACK: state_in = S_FB;
                  jlti_pkg::OP_TARGET:   state_in = S_CHECK;
                  jlti_pkg::OP_TICK:     state_in = S_TSEL;
                  default:               state_in = S_DONE;
               endcase
            end
         end
         S_FB: begin
            cmd.fb   = 1'b1;
            state_in = S_DONE;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.reject ? S_DONE : S_MAXD;
         end
         S_MAXD: begin
            cmd.maxd_step = 1'b1;
            if (stat.j_last) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_n = 1'b1;
            state_in  = S_NDIV;
         end
         S_NDIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_NSTORE;
         end
         S_NSTORE: begin
            cmd.n_store = 1'b1;
            state_in    = S_DONE;
         end
         S_TSEL: begin
            cmd.tsel = 1'b1;
            state_in = (stat.queue_empty || stat.short_seg) ? S_DONE : S_TMUL;
         end
         S_TMUL: begin
            cmd.tmul = 1'b1;
            state_in = S_TDIV;
         end
         S_TDIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_TSTORE;
         end
         S_TSTORE: begin
            cmd.tstore = 1'b1;
            state_in   = stat.j_last ? S_TADV : S_TMUL;
         end
         S_TADV: begin
            cmd.tadv = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> src/jlti_dp.sv
// Datapath of the interpolator: joint state, segment queue, shared divider,
// configuration registers and the result register. Depends on jlti_pkg.
`default_nettype none

module jlti_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire jlti_pkg::cmd_type            cmd,
   output jlti_pkg::stat_type                stat,
   input  wire logic [jlti_pkg::IN_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [jlti_pkg::OUT_W-1:0]        rsp_tdata,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [jlti_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [jlti_pkg::LIM_W-1:0]   csr_data
);

   localparam int J  = jlti_pkg::JOINTS;
   localparam int S  = jlti_pkg::SEGMENTS;
   localparam int AW = jlti_pkg::ANG_W;
   localparam int MW = jlti_pkg::MAG_W;

   logic [jlti_pkg::LIM_W-1:0]   angle_limit_ff, angle_limit_in;
   logic [jlti_pkg::SPEED_W-1:0] speed_limit_ff, speed_limit_in;
   logic [jlti_pkg::RATE_W-1:0]  rate_ff, rate_in;

   logic signed [AW-1:0] tgt_ff [J], tgt_in [J];
   logic [jlti_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic signed [AW-1:0] meas_ff [J], meas_in [J];
   logic signed [AW-1:0] held_ff [J], held_in [J];
   logic init_ff, init_in;

   logic signed [AW-1:0] sstart_ff [S][J], sstart_in [S][J];
   logic signed [AW-1:0] send_ff [S][J], send_in [S][J];
   logic [jlti_pkg::STEP_W-1:0] ssteps_ff [S], ssteps_in [S];
   logic [jlti_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [jlti_pkg::SEG_W-1:0]  head_ff, head_in;
   logic [jlti_pkg::STEP_W-1:0] index_ff, index_in;

   logic [jlti_pkg::JIDX_W-1:0] jidx_ff, jidx_in;
   logic [MW-1:0]               maxd_ff, maxd_in;
   logic [jlti_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [jlti_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [jlti_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [jlti_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   jlti_pkg::status_type        status_ff, status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [jlti_pkg::OUT_W-1:0]  rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic signed [MW-1:0] tdiff, sdiff, sval;
   logic [MW-1:0]        tmag, smag;
   logic                 ang_bad, speed_bad;
   jlti_pkg::status_type chk_code;
   logic                 chk_rej;
   logic [jlti_pkg::DVS_W:0] trial, tsub;
   logic                 ge;
   logic [jlti_pkg::PROD_W-1:0] nprod;
   logic [jlti_pkg::DVD_W-1:0]  iprod;
   logic [jlti_pkg::SEG_W-1:0]  slot;
   logic [jlti_pkg::STEP_W-1:0] head_n;
   logic [jlti_pkg::STEP_W:0]   idx_next;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      tdiff = MW'(tgt_ff[jidx_ff]) - MW'(meas_ff[jidx_ff]);
      tmag  = tdiff[MW-1] ? MW'(-tdiff) : MW'(tdiff);
      sdiff = MW'(send_ff[head_ff][jidx_ff]) - MW'(sstart_ff[head_ff][jidx_ff]);
      smag  = sdiff[MW-1] ? MW'(-sdiff) : MW'(sdiff);
      sval  = sdiff[MW-1] ? MW'(sstart_ff[head_ff][jidx_ff]) - $signed(dvd_ff[MW-1:0])
                          : MW'(sstart_ff[head_ff][jidx_ff]) + $signed(dvd_ff[MW-1:0]);
      ang_bad = 1'b0;
      for (int j = 0; j < J; j++) begin
         if ($signed(MW'(tgt_ff[j])) > $signed({2'b00, angle_limit_ff})) ang_bad = 1'b1;
      end
      speed_bad = (speed_ff == '0) || (speed_ff > speed_limit_ff);
      chk_rej   = 1'b1;
      if (!init_ff) chk_code = jlti_pkg::ST_UNINIT;
      else if (ang_bad) chk_code = jlti_pkg::ST_ANGLE_REJ;
      else if (speed_bad) chk_code = jlti_pkg::ST_SPEED_REJ;
      else if (count_ff >= jlti_pkg::CNT_W'(S)) chk_code = jlti_pkg::ST_FULL;
      else begin
         chk_code = jlti_pkg::ST_ACCEPT;
         chk_rej  = 1'b0;
      end
      trial  = {rem_ff, dvd_ff[jlti_pkg::DVD_W-1]};
      tsub   = trial - {1'b0, dvs_ff};
      ge     = (trial >= {1'b0, dvs_ff});
      nprod  = maxd_ff * rate_ff;
      iprod  = smag * index_ff;
      slot   = head_ff + count_ff[jlti_pkg::SEG_W-1:0];
      head_n = ssteps_ff[head_ff];
      idx_next = {1'b0, index_ff} + 1'b1;
   end

   always_comb begin
      stat.reject      = chk_rej;
      stat.queue_empty = (count_ff == '0);
      stat.short_seg   = (head_n < jlti_pkg::STEP_W'(2));
      stat.j_last      = (jidx_ff == jlti_pkg::JIDX_W'(J - 1));
      stat.div_last    = (dcnt_ff == jlti_pkg::DCNT_W'(1));
      stat.out_free    = !rsp_valid_ff || rsp_tready;
      stat.seg_count   = count_ff;
   end

   always_comb begin
      angle_limit_in = angle_limit_ff;
      speed_limit_in = speed_limit_ff;
      rate_in        = rate_ff;
      tgt_in = tgt_ff;   speed_in = speed_ff;
      meas_in = meas_ff; held_in = held_ff; init_in = init_ff;
      sstart_in = sstart_ff; send_in = send_ff; ssteps_in = ssteps_ff;
      count_in = count_ff; head_in = head_ff; index_in = index_ff;
      jidx_in = jidx_ff; maxd_in = maxd_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; dvs_in = dvs_ff; dcnt_in = dcnt_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            jlti_pkg::CSR_ANGLE_LIMIT: angle_limit_in = csr_data;
            jlti_pkg::CSR_SPEED_LIMIT: speed_limit_in = csr_data;
            jlti_pkg::CSR_UPDATE_RATE: rate_in = csr_data[jlti_pkg::RATE_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         for (int j = 0; j < J; j++) tgt_in[j] = req_tdata[j*AW +: AW];
         speed_in  = req_tdata[J*AW +: jlti_pkg::SPEED_W];
         status_in = jlti_pkg::ST_HOLD;
      end

      if (cmd.fb) begin
         meas_in = tgt_ff;
         if (!init_ff) begin
            held_in = tgt_ff;
            init_in = 1'b1;
         end
         status_in = (count_ff != '0) ? jlti_pkg::ST_MOVE : jlti_pkg::ST_HOLD;
      end

      if (cmd.check) begin
         if (chk_rej) status_in = chk_code;
         maxd_in = '0;
         jidx_in = '0;
      end

      if (cmd.maxd_step) begin
         if (tmag > maxd_ff) maxd_in = tmag;
         jidx_in = jidx_ff + 1'b1;
      end

      if (cmd.mul_n) begin
         dvd_in  = jlti_pkg::DVD_W'(nprod);
         dvs_in  = speed_ff;
         rem_in  = '0;
         dcnt_in = jlti_pkg::DCNT_W'(jlti_pkg::DVD_W);
      end

      if (cmd.tmul) begin
         dvd_in  = iprod;
         dvs_in  = jlti_pkg::DVS_W'(head_n - 1'b1);
         rem_in  = '0;
         dcnt_in = jlti_pkg::DCNT_W'(jlti_pkg::DVD_W);
      end

      if (cmd.div_step) begin
         rem_in  = ge ? tsub[jlti_pkg::DVS_W-1:0] : trial[jlti_pkg::DVS_W-1:0];
         dvd_in  = {dvd_ff[jlti_pkg::DVD_W-2:0], ge};
         dcnt_in = dcnt_ff - 1'b1;
      end

      if (cmd.n_store) begin
         status_in = jlti_pkg::ST_ACCEPT;
         if (dvd_ff != '0) begin
            for (int j = 0; j < J; j++) begin
               sstart_in[slot][j] = meas_ff[j];
               send_in[slot][j]   = tgt_ff[j];
            end
            if (dvd_ff > jlti_pkg::DVD_W'(jlti_pkg::MAX_STEPS)) begin
               ssteps_in[slot] = jlti_pkg::STEP_W'(jlti_pkg::MAX_STEPS);
               status_in       = jlti_pkg::ST_CAPPED;
            end else begin
               ssteps_in[slot] = dvd_ff[jlti_pkg::STEP_W-1:0];
            end
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.tsel) begin
         jidx_in = '0;
         if (count_ff != '0 && head_n < jlti_pkg::STEP_W'(2)) begin
            held_in   = send_ff[head_ff];
            head_in   = head_ff + 1'b1;
            count_in  = count_ff - 1'b1;
            index_in  = '0;
            status_in = jlti_pkg::ST_MOVE;
         end
      end

      if (cmd.tstore) begin
         held_in[jidx_ff] = sval[AW-1:0];
         jidx_in = jidx_ff + 1'b1;
      end

      if (cmd.tadv) begin
         status_in = jlti_pkg::ST_MOVE;
         if (idx_next >= {1'b0, head_n}) begin
            head_in  = head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            index_in = '0;
         end else begin
            index_in = idx_next[jlti_pkg::STEP_W-1:0];
         end
      end

      // result register: hold until taken, refill from the held setpoint
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         for (int j = 0; j < J; j++) rsp_data_in[j*AW +: AW] = held_ff[j];
         rsp_data_in[J*AW +: jlti_pkg::ST_W] = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_limit_ff <= jlti_pkg::ANGLE_LIMIT_RST;
         speed_limit_ff <= jlti_pkg::SPEED_LIMIT_RST;
         rate_ff        <= jlti_pkg::UPDATE_RATE_RST;
         for (int j = 0; j < J; j++) begin
            meas_ff[j] <= '0;
            held_ff[j] <= '0;
         end
         init_ff      <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         angle_limit_ff <= angle_limit_in;
         speed_limit_ff <= speed_limit_in;
         rate_ff        <= rate_in;
         meas_ff        <= meas_in;
         held_ff        <= held_in;
         init_ff        <= init_in;
         count_ff       <= count_in;
         head_ff        <= head_in;
         index_ff       <= index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      speed_ff    <= speed_in;
      sstart_ff   <= sstart_in;
      send_ff     <= send_in;
      ssteps_ff   <= ssteps_in;
      jidx_ff     <= jidx_in;
      maxd_ff     <= maxd_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      dcnt_ff     <= dcnt_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> src/joint_linear_trajectory_interpolator.sv
// One item at a time; the result beat is valid the cycle after the result load.
// An accepted target runs the 38-step restoring divider once, and a moving
// tick runs it once per joint. Synchronous active-high reset clears the joint
// state, the segment queue and the result register and loads register defaults.
// Depends on jlti_pkg, jlti_ctrl and jlti_dp.
`default_nettype none

module joint_linear_trajectory_interpolator (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // angle_0..angle_5 (21 bit each), move_speed (20 bit), zero pad
   input  wire logic [jlti_pkg::IN_W-1:0]    req_tdata,
   // opcode
   input  wire logic [jlti_pkg::OP_W-1:0]    req_tuser,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // setpoint_0..setpoint_5 (21 bit each), status (3 bit), zero pad
   output logic [jlti_pkg::OUT_W-1:0]        rsp_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [jlti_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [jlti_pkg::LIM_W-1:0]   csr_data
);

   jlti_pkg::cmd_type  cmd;
   jlti_pkg::stat_type stat;

   // sequencer: take a beat, walk the item's steps, hand over the result
   jlti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   // joint state, queue, divider and result register
   jlti_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

`ifndef SYNTHESIS
   // one item in flight: no second beat straight after an accepted one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input beat taken while an item is in flight");

   // the queue never holds more segments than it has slots
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      stat.seg_count <= jlti_pkg::CNT_W'(jlti_pkg::SEGMENTS))
      else $error("segment count beyond queue depth");

   // a waiting result beat is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register loaded while a beat waits");
`endif

endmodule

`default_nettype wire

>>> dv/joint_linear_trajectory_interpolator_tb.sv
// Self-checking testbench for the joint linear trajectory interpolator.
// Drives directed and random items over the stream ports, predicts every beat;
// depends on jlti_pkg and joint_linear_trajectory_interpolator only.
`default_nettype none

module joint_linear_trajectory_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jlti_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 300;   // longer than the slowest tick
   localparam int ANG_MIN = -1048576;
   localparam int ANG_MAX = 1048575;

   typedef logic [JOINTS-1:0][ANG_W-1:0] joint_vec_type;

   typedef struct packed {
      status_type status;
      joint_vec_type setpoint;
   } setpoint_beat_type;

   typedef struct {
      opcode_type       op;
      int               a0;
      int               step;
      int               speed;
      bit               typed;
      status_type       status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [IN_W-1:0]  req_tdata  = '0;
   logic [OP_W-1:0]  req_tuser  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [OUT_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_index  = '0;
   logic [LIM_W-1:0] csr_data   = '0;

   joint_linear_trajectory_interpolator DUT (.*);

   always #1 clock = ~clock;

   // Predictor state: a private copy of the block's registers, joints and queue
   int          lim_angle, lim_speed, tick_rate;
   int          meas_pos [JOINTS];
   int          hold_pos [JOINTS];
   bit          primed;
   int          seg_from [SEGMENTS][JOINTS];
   int          seg_to   [SEGMENTS][JOINTS];
   int          seg_len  [SEGMENTS];
   int          seg_used, seg_first, seg_point;

   setpoint_beat_type pending_beats[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int sext(input logic [ANG_W-1:0] v);
      return int'(signed'(v));
   endfunction

   function automatic int abs_of(input int v);
      return v < 0 ? -v : v;
   endfunction

   // Point i of n, truncated toward zero
   function automatic int lerp_point(input int s, input int e, input int i, input int n);
      longint d, q;
      d = longint'(e) - longint'(s);
      q = (d < 0 ? -d : d) * longint'(i) / longint'(n - 1);
      return int'(d < 0 ? s - q : s + q);
   endfunction

   function automatic longint steps_for(input joint_vec_type ang, input int spd);
      longint maxd;
      maxd = 0;
      for (int j = 0; j < JOINTS; j++)
         if (abs_of(sext(ang[j]) - meas_pos[j]) > maxd) maxd = abs_of(sext(ang[j]) - meas_pos[j]);
      return spd == 0 ? 0 : maxd * tick_rate / spd;
   endfunction

   function automatic status_type load_target(input joint_vec_type ang, input int spd);
      longint n;
      int slot;
      status_type st;
      st = ST_ACCEPT;
      if (!primed) return ST_UNINIT;
      for (int j = 0; j < JOINTS; j++)
         if (sext(ang[j]) > lim_angle) return ST_ANGLE_REJ;
      if (spd == 0 || spd > lim_speed) return ST_SPEED_REJ;
      if (seg_used >= SEGMENTS) return ST_FULL;
      n = steps_for(ang, spd);
      if (n == 0) return ST_ACCEPT;
      if (n > MAX_STEPS) begin
         n = MAX_STEPS;
         st = ST_CAPPED;
      end
      slot = (seg_first + seg_used) % SEGMENTS;
      for (int j = 0; j < JOINTS; j++) begin
         seg_from[slot][j] = meas_pos[j];
         seg_to[slot][j] = sext(ang[j]);
      end
      seg_len[slot] = int'(n);
      seg_used++;
      return st;
   endfunction

   function automatic status_type advance_tick();
      int h, n;
      if (seg_used == 0) return ST_HOLD;
      h = seg_first;
      n = seg_len[h];
      if (n < 2) begin
         for (int j = 0; j < JOINTS; j++) hold_pos[j] = seg_to[h][j];
      end else begin
         if (seg_point > n - 1) seg_point = n - 1;
         for (int j = 0; j < JOINTS; j++)
            hold_pos[j] = lerp_point(seg_from[h][j], seg_to[h][j], seg_point, n);
      end
      if (n < 2 || seg_point + 1 >= n) begin
         seg_first = (h + 1) % SEGMENTS;
         seg_used--;
         seg_point = 0;
      end else begin
         seg_point++;
      end
      return ST_MOVE;
   endfunction

   function automatic setpoint_beat_type predict_beat(input opcode_type op,
                                                      input joint_vec_type ang,
                                                      input int spd);
      setpoint_beat_type b;
      case (op)
         OP_FEEDBACK: begin
            for (int j = 0; j < JOINTS; j++) meas_pos[j] = sext(ang[j]);
            if (!primed) begin
               hold_pos = meas_pos;
               primed = 1'b1;
            end
            b.status = seg_used != 0 ? ST_MOVE : ST_HOLD;
         end
         OP_TARGET: b.status = load_target(ang, spd);
         OP_TICK:   b.status = advance_tick();
         default:   b.status = ST_HOLD;
      endcase
      for (int j = 0; j < JOINTS; j++) b.setpoint[j] = hold_pos[j][ANG_W-1:0];
      return b;
   endfunction

   // Present one beat, hold it until accepted, then queue its expectation.
   // A typed status, where given, overrides the predicted one.
   task automatic send_item(input opcode_type op, input joint_vec_type ang, input int spd,
                            input bit typed, input status_type want);
      setpoint_beat_type b;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tdata <= {{(IN_W - JOINTS*ANG_W - SPEED_W){1'b0}}, spd[SPEED_W-1:0], ang};
      req_tuser <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      b = predict_beat(op, ang, spd);
      if (typed) b.status = want;
      pending_beats = {pending_beats, b};
   endtask

   // Leave valid high: the caller drops it after the last write of a batch
   task automatic write_csr(input logic [CSR_W-1:0] idx, input int val);
      csr_index <= idx;
      csr_data <= val[LIM_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ANGLE_LIMIT: lim_angle = val & 32'hFFFFF;
         CSR_SPEED_LIMIT: lim_speed = val & 32'hFFFFF;
         default:         tick_rate = val & 32'h3FF;
      endcase
   endtask

   // Wait for every expected beat, then let a slow tick finish before idle work
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic joint_vec_type ramp(input int a0, input int step);
      joint_vec_type v;
      for (int j = 0; j < JOINTS; j++) v[j] = 21'(a0 + j * step);
      return v;
   endfunction

   function automatic int clamp_angle(input int v, input int hi);
      if (v < ANG_MIN) return ANG_MIN;
      return v > hi ? hi : v;
   endfunction

   // Mostly reachable short moves; some raw noise so every field bit toggles
   task automatic send_random_item();
      joint_vec_type ang;
      int spd, pick, reach, hi;
      pick = $urandom_range(99);
      for (int j = 0; j < JOINTS; j++) ang[j] = 21'($urandom);
      spd = $urandom_range(1048575);
      if (pick < 20) begin
         if ($urandom_range(1))
            for (int j = 0; j < JOINTS; j++)
               ang[j] = 21'(clamp_angle(meas_pos[j] + $urandom_range(8000) - 4000, ANG_MAX));
         send_item(OP_FEEDBACK, ang, spd, 1'b0, ST_HOLD);
      end else if (pick < 50) begin
         if ($urandom_range(9) != 0) begin
            hi = lim_angle > ANG_MAX ? ANG_MAX : lim_angle;
            reach = 1 << $urandom_range(16);
            spd = $urandom_range(lim_speed, 1);
            for (int k = 0; k < 20; k++) begin
               for (int j = 0; j < JOINTS; j++)
                  ang[j] = 21'(clamp_angle(meas_pos[j] + $urandom_range(2 * reach) - reach, hi));
               if (steps_for(ang, spd) <= 48) break;
               reach = reach / 2;
            end
            if (steps_for(ang, spd) > 48)
               for (int j = 0; j < JOINTS; j++) ang[j] = meas_pos[j][ANG_W-1:0];
         end
         // keep every queued move short so ticks can always drain the queue
         if (steps_for(ang, spd) > 48) spd = 0;
         send_item(OP_TARGET, ang, spd, 1'b0, ST_HOLD);
      end else if (pick < 95) begin
         send_item(OP_TICK, ang, spd, 1'b0, ST_HOLD);
      end else begin
         send_item(OP_NONE, ang, spd, 1'b0, ST_HOLD);
      end
   endtask

   // Directed table under reset register values: errors before and after
   // priming, boundary angle and speed, zero-step and one-point moves, full queue
   stim_row_type directed[] = '{
      '{OP_TARGET,   1000,     0, 1000,   1, ST_UNINIT},
      '{OP_TICK,     0,        0, 0,      1, ST_HOLD},
      '{OP_NONE,     -1,       0, 1048575, 1, ST_HOLD},
      '{OP_FEEDBACK, -1048576, 0, 0,      1, ST_HOLD},
      '{OP_FEEDBACK, 0,        100, 0,    1, ST_HOLD},
      '{OP_TARGET,   368641,   0, 1000,   1, ST_ANGLE_REJ},
      '{OP_TARGET,   368640,   0, 0,      1, ST_SPEED_REJ},
      '{OP_TARGET,   368640,   0, 368641, 1, ST_SPEED_REJ},
      '{OP_TARGET,   0,        100, 1,    1, ST_ACCEPT},
      '{OP_TARGET,   1024,     0, 20480,  1, ST_ACCEPT},
      '{OP_TICK,     0,        0, 0,      0, ST_HOLD},
      '{OP_TICK,     0,        0, 0,      1, ST_HOLD},
      '{OP_TARGET,   -4096,    0, 10240,  1, ST_ACCEPT},
      '{OP_TARGET,   2048,     0, 4096,   1, ST_ACCEPT},
      '{OP_TARGET,   2048,     3, 4096,   1, ST_ACCEPT},
      '{OP_TARGET,   -2048,    -7, 4096,  1, ST_ACCEPT},
      '{OP_TARGET,   0,        0, 4096,   1, ST_FULL},
      '{OP_FEEDBACK, -100,     -1, 0,     0, ST_HOLD},
      '{OP_TICK,     0,        0, 0,      0, ST_HOLD},
      '{OP_FEEDBACK, 1048575,  0, 0,      0, ST_HOLD},
      '{OP_TICK,     0,        0, 0,      0, ST_HOLD},
      '{OP_TICK,     0,        0, 0,      0, ST_HOLD}
   };

   // Register settings per random phase: angle, speed, rate; extremes included
   int phase_cfg [5][3] = '{
      '{1048575, 1048575, 1000},
      '{0,       1,       1},
      '{200000,  50000,   500},
      '{1048575, 368640,  20},
      '{368640,  368640,  20}
   };
   int phase_idle [5][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{27, 27}, '{0, 0}};

   // Stimulus
   initial begin
      lim_angle = ANGLE_LIMIT_RST;
      lim_speed = SPEED_LIMIT_RST;
      tick_rate = UPDATE_RATE_RST;
      meas_pos = '{default: 0};
      hold_pos = '{default: 0};
      primed = 1'b0;
      seg_used = 0;
      seg_first = 0;
      seg_point = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[r])
         send_item(directed[r].op, ramp(directed[r].a0, directed[r].step),
                   directed[r].speed, directed[r].typed, directed[r].status);

      for (int p = 0; p < 5; p++) begin
         settle();
         write_csr(CSR_ANGLE_LIMIT, phase_cfg[p][0]);
         write_csr(CSR_SPEED_LIMIT, phase_cfg[p][1]);
         write_csr(CSR_UPDATE_RATE, phase_cfg[p][2]);
         csr_valid <= 1'b0;
         send_idle_pct = phase_idle[p][0];
         recv_stall_pct = phase_idle[p][1];
         repeat (190) send_random_item();
      end

      // Drain the queue, then a capped move last: its 65535 points never finish
      while (seg_used != 0) send_item(OP_TICK, '0, 0, 1'b0, ST_HOLD);
      send_item(OP_FEEDBACK, '0, 0, 1'b0, ST_HOLD);
      send_item(OP_TARGET, ramp(368640, 0), 1, 1'b1, ST_CAPPED);
      repeat (3) send_item(OP_TICK, '0, 0, 1'b0, ST_HOLD);

      settle();
      if (fail_count == 0)
         $display("joint_linear_trajectory_interpolator_tb: PASS");
      else
         $display("joint_linear_trajectory_interpolator_tb: FAIL");
      $finish;
   end

   // Receiver: stall at random, check each accepted beat against the oldest expectation
   always @(posedge clock) begin
      setpoint_beat_type want;
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $display("unexpected result beat at %0t", $realtime);
            fail_count++;
         end else begin
            want = pending_beats.pop_front();
            for (int j = 0; j < JOINTS; j++)
               if (rsp_tdata[j*ANG_W +: ANG_W] !== want.setpoint[j])
                  report_mismatch($sformatf("setpoint_%0d", j),
                                  sext(rsp_tdata[j*ANG_W +: ANG_W]), sext(want.setpoint[j]));
            if (rsp_tdata[JOINTS*ANG_W +: ST_W] !== want.status)
               report_mismatch("status", rsp_tdata[JOINTS*ANG_W +: ST_W], want.status);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("joint_linear_trajectory_interpolator_tb: FAIL");
         $finish;
      end
   end

endmodule

`default_nettype wire

>>> filelist.f
src/jlti_pkg.sv
src/jlti_ctrl.sv
src/jlti_dp.sv
src/joint_linear_trajectory_interpolator.sv
dv/joint_linear_trajectory_interpolator_tb.sv
